// ===== hdl/bspline_point_evaluator_defines.svh =====
// Assertion macros shared by the evaluator modules.
`ifndef BSPLINE_POINT_EVALUATOR_DEFINES_SVH
`define BSPLINE_POINT_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define BPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BPE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/bpe_pkg.sv =====
package bpe_pkg;

    localparam int MAX_POINTS = 32;
    localparam int MAX_DEGREE = 7;
    localparam int FRAC_BITS  = 16;
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int WORK_DEPTH = MAX_DEGREE + 1;
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
    localparam int PNT_AW     = $clog2(MAX_POINTS);
    localparam int WORK_AW    = $clog2(WORK_DEPTH);
    localparam int COORD_W    = 32;
    localparam int PROD_W     = COORD_W + 1 + QUOT_W + 1;

    localparam logic [1:0] OP_KNOT  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    localparam logic [1:0] CFG_DEGREE      = 2'd0;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd1;

    // element 0 is x, 1 is y, 2 is z
    typedef logic [2:0][COORD_W-1:0] point_t;

    typedef struct packed {
        logic                start;
        logic [COORD_W-1:0]  num;
        logic [COORD_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
    } div_rsp_t;

endpackage

// ===== hdl/bpe_ram.sv =====
module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bpe_div.sv =====
`include "bspline_point_evaluator_defines.svh"

// (num << FRAC_BITS) / den for num <= den, one quotient bit per cycle
module bpe_div
    import bpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [COORD_W:0]   rem_reg, rem_next;
    logic [COORD_W-1:0] den_reg, den_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [$clog2(QUOT_W+1)-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               ge;
    logic [COORD_W:0]   rem_sub;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, den_reg};
        rem_sub   = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            cnt_next  = ($clog2(QUOT_W+1))'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            rem_next  = {rem_sub[COORD_W-1:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `BPE_ASSERT_IMP(a_start_idle, clk, rst_n, req.start, !busy_reg)
    `BPE_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `BPE_ASSERT_IMP(a_busy_count, clk, rst_n, busy_reg, cnt_reg != 0)

endmodule

// ===== hdl/bspline_point_evaluator.sv =====
// B-spline point evaluator, de Boor's algorithm, 3D, Q16.16.
// Input stream (s_axis): tuser is the op. Knot writes and control point writes
// give no result. An evaluate runs alone: span search, copy of degree+1 points
// into the work memory, then degree*(degree+1)/2 blend steps that share one
// serial divider and one multiplier. The span search reads at most
// point_count-degree knots; a step whose knot difference is zero skips the
// divider and the multiplier and keeps the left point.
// Output stream (m_axis): one transfer per evaluate, held in an output register;
// a new item is taken while it waits, but a later result stalls in its final
// state until the register is free.
// Config channel: ready always high, index 0 degree, index 1 point_count.
// Reset restores degree 3 and point_count 4; knot and point memories are not
// cleared and read as garbage until written.
`include "bspline_point_evaluator_defines.svh"

module bspline_point_evaluator
    import bpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot[5:0], knot_value[37:6], px[69:38], py[101:70], pz[133:102],
    // param_u[165:134], zero[167:166]
    input  logic [167:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // curve_x[31:0], curve_y[63:32], curve_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // out_of_range[0]
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [5:0]   cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KN   = 4'd1;
    localparam logic [3:0] S_KD   = 4'd2;
    localparam logic [3:0] S_SRCH = 4'd3;
    localparam logic [3:0] S_CP   = 4'd4;
    localparam logic [3:0] S_BA   = 4'd5;
    localparam logic [3:0] S_BB   = 4'd6;
    localparam logic [3:0] S_BC   = 4'd7;
    localparam logic [3:0] S_BDIV = 4'd8;
    localparam logic [3:0] S_BMUL = 4'd9;
    localparam logic [3:0] S_BADD = 4'd10;
    localparam logic [3:0] S_BWR  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_FIN2 = 4'd13;

    logic [5:0]  in_slot;
    logic [31:0] in_knot, in_u;
    point_t      in_pt;

    assign in_slot = s_axis_tdata[5:0];
    assign in_knot = s_axis_tdata[37:6];
    assign in_pt   = s_axis_tdata[133:38];
    assign in_u    = s_axis_tdata[165:134];

    logic [3:0]   state_reg, state_next;
    logic [2:0]   deg_reg, deg_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [2:0]   d_reg, d_next;
    logic [5:0]   n_reg, n_next;
    logic [31:0]  u_reg, u_next;
    logic [31:0]  kn_reg, kn_next;
    logic         flag_reg, flag_next;
    logic [5:0]   i_reg, i_next;
    logic [5:0]   dec_reg, dec_next;
    logic [2:0]   j_reg, j_next;
    logic [3:0]   k_reg, k_next;
    logic [31:0]  a_reg, a_next;
    point_t       w0_reg, w0_next;
    point_t       w1_reg, w1_next;
    point_t       res_reg, res_next;
    logic [1:0]   c_reg, c_next;
    logic [QUOT_W-1:0] alpha_reg, alpha_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    point_t       out_reg, out_next;
    logic         oflag_reg, oflag_next;
    logic         ovalid_reg, ovalid_next;

    logic               knot_we;
    logic [KNOT_AW-1:0] knot_waddr, knot_raddr;
    logic [31:0]        knot_rdata;
    logic               pnt_we;
    logic [PNT_AW-1:0]  pnt_waddr, pnt_raddr;
    point_t             pnt_rdata;
    logic               work_we;
    logic [WORK_AW-1:0] work_waddr, work_raddr;
    point_t             work_wdata, work_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2:0]  d_cl;
    logic [5:0]  n_cl;
    logic [6:0]  dj_sum;
    logic [6:0]  dk_sum;
    logic [31:0] den, num;
    logic signed [COORD_W:0] diff;
    logic signed [PROD_W-1:0] t_round;
    logic [3:0]  j_plus2;

    bpe_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (knot_waddr),
        .wdata (in_knot),
        .raddr (knot_raddr),
        .rdata (knot_rdata)
    );

    bpe_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk   (clk),
        .we    (pnt_we),
        .waddr (pnt_waddr),
        .wdata (in_pt),
        .raddr (pnt_raddr),
        .rdata (pnt_rdata)
    );

    bpe_ram #(.WIDTH(3*COORD_W), .DEPTH(WORK_DEPTH)) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    bpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = oflag_reg;

    always_comb
    begin
        d_cl    = (deg_reg == 3'd0) ? 3'd1 : deg_reg;
        if (cnt_reg < {3'd0, d_cl} + 6'd1)
            n_cl = {3'd0, d_cl} + 6'd1;
        else if (cnt_reg > 6'(MAX_POINTS))
            n_cl = 6'(MAX_POINTS);
        else
            n_cl = cnt_reg;
        dj_sum  = {1'b0, dec_reg} + 7'd1 + {4'd0, j_reg};
        dk_sum  = {1'b0, dec_reg} + {3'd0, k_reg} + {4'd0, j_reg};
        den     = knot_rdata - a_reg;
        num     = (u_reg > a_reg) ? u_reg - a_reg : 32'd0;
        if (num > den)
            num = den;
        diff    = $signed({w1_reg[c_reg][COORD_W-1], w1_reg[c_reg]})
                - $signed({w0_reg[c_reg][COORD_W-1], w0_reg[c_reg]});
        t_round = prod_reg + PROD_W'(1 << (FRAC_BITS - 1));
        j_plus2 = {1'b0, j_reg} + 4'd2;
    end

    always_comb
    begin
        state_next  = state_reg;
        deg_next    = deg_reg;
        cnt_next    = cnt_reg;
        d_next      = d_reg;
        n_next      = n_reg;
        u_next      = u_reg;
        kn_next     = kn_reg;
        flag_next   = flag_reg;
        i_next      = i_reg;
        dec_next    = dec_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        w0_next     = w0_reg;
        w1_next     = w1_reg;
        res_next    = res_reg;
        c_next      = c_reg;
        alpha_next  = alpha_reg;
        prod_next   = prod_reg;
        out_next    = out_reg;
        oflag_next  = oflag_reg;
        ovalid_next = ovalid_reg & ~m_axis_tready;

        knot_we     = 1'b0;
        knot_waddr  = in_slot;
        knot_raddr  = '0;
        pnt_we      = 1'b0;
        pnt_waddr   = in_slot[PNT_AW-1:0];
        pnt_raddr   = '0;
        work_we     = 1'b0;
        work_waddr  = j_reg;
        work_wdata  = res_reg;
        work_raddr  = '0;
        div_req     = '{start: 1'b0, num: num, den: den};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEGREE:      deg_next = cfg_data[2:0];
                CFG_POINT_COUNT: cnt_next = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (s_axis_tuser)
                        OP_KNOT:  knot_we = (in_slot < 6'(KNOT_DEPTH));
                        OP_POINT: pnt_we  = (in_slot < 6'(MAX_POINTS));
                        OP_EVAL:
                        begin
                            d_next     = d_cl;
                            n_next     = n_cl;
                            u_next     = in_u;
                            flag_next  = 1'b0;
                            knot_raddr = n_cl;
                            state_next = S_KN;
                        end
                        default: ;
                    endcase
                end
            end
            S_KN:
            begin
                kn_next    = knot_rdata;
                knot_raddr = {3'd0, d_reg};
                state_next = S_KD;
            end
            S_KD:
            begin
                if (u_reg > kn_reg)
                begin
                    u_next    = kn_reg;
                    flag_next = 1'b1;
                end
                else if (u_reg < knot_rdata)
                begin
                    u_next    = knot_rdata;
                    flag_next = 1'b1;
                end
                i_next     = {3'd0, d_reg} + 6'd1;
                knot_raddr = {3'd0, d_reg} + 6'd1;
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (i_reg < n_reg && u_reg > knot_rdata)
                begin
                    i_next     = i_reg + 6'd1;
                    knot_raddr = i_reg + 6'd1;
                end
                else
                begin
                    dec_next   = i_reg - {3'd0, d_reg} - 6'd1;
                    pnt_raddr  = PNT_AW'(i_reg - {3'd0, d_reg} - 6'd1);
                    j_next     = '0;
                    state_next = S_CP;
                end
            end
            S_CP:
            begin
                work_we    = 1'b1;
                work_waddr = j_reg;
                work_wdata = pnt_rdata;
                if (j_reg == d_reg)
                begin
                    j_next     = '0;
                    k_next     = {1'b0, d_reg} + 4'd1;
                    state_next = S_BA;
                end
                else
                begin
                    j_next    = j_reg + 3'd1;
                    pnt_raddr = PNT_AW'(dec_reg + {3'd0, j_reg} + 6'd1);
                end
            end
            S_BA:
            begin
                knot_raddr = dj_sum[KNOT_AW-1:0];
                work_raddr = j_reg;
                state_next = S_BB;
            end
            S_BB:
            begin
                a_next     = knot_rdata;
                w0_next    = work_rdata;
                knot_raddr = dk_sum[KNOT_AW-1:0];
                work_raddr = j_reg + 3'd1;
                state_next = S_BC;
            end
            S_BC:
            begin
                w1_next = work_rdata;
                if (knot_rdata <= a_reg)
                begin
                    state_next = S_BWR;
                    res_next   = w0_reg;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_BDIV;
                end
            end
            S_BDIV:
            begin
                if (div_rsp.done)
                begin
                    alpha_next = div_rsp.quot;
                    c_next     = '0;
                    state_next = S_BMUL;
                end
            end
            S_BMUL:
            begin
                prod_next  = $signed({1'b0, alpha_reg}) * diff;
                state_next = S_BADD;
            end
            S_BADD:
            begin
                res_next[c_reg] = w0_reg[c_reg]
                                + COORD_W'(t_round >>> FRAC_BITS);
                if (c_reg == 2'd2)
                begin
                    state_next = S_BWR;
                end
                else
                begin
                    c_next     = c_reg + 2'd1;
                    state_next = S_BMUL;
                end
            end
            S_BWR:
            begin
                work_we    = 1'b1;
                work_waddr = j_reg;
                work_wdata = res_reg;
                if (j_plus2 + 4'd1 <= k_reg)
                begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_BA;
                end
                else if (k_reg == 4'd2)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    j_next     = '0;
                    k_next     = k_reg - 4'd1;
                    dec_next   = dec_reg + 6'd1;
                    state_next = S_BA;
                end
            end
            S_FIN:
            begin
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    out_next    = work_rdata;
                    oflag_next  = flag_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            deg_reg    <= 3'd3;
            cnt_reg    <= 6'd4;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            deg_reg    <= deg_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        n_reg     <= n_next;
        u_reg     <= u_next;
        kn_reg    <= kn_next;
        flag_reg  <= flag_next;
        i_reg     <= i_next;
        dec_reg   <= dec_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        a_reg     <= a_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        res_reg   <= res_next;
        c_reg     <= c_next;
        alpha_reg <= alpha_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
        oflag_reg <= oflag_next;
    end

    `BPE_ASSERT_IMP(a_work_addr, clk, rst_n, work_we && state_reg != S_IDLE,
                    work_waddr <= d_reg)
    `BPE_ASSERT_IMP(a_div_wait, clk, rst_n, div_rsp.done, state_reg == S_BDIV)
    `BPE_ASSERT_IMP(a_round_left, clk, rst_n, state_reg == S_BA, k_reg >= 4'd2)
    `BPE_ASSERT_NXT(a_result_out, clk, rst_n,
                    state_reg == S_FIN2 && (!ovalid_reg || m_axis_tready),
                    m_axis_tvalid && state_reg == S_IDLE)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import bpe_pkg::*;
();

    localparam logic [1:0] OP_NOP = 2'd3;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [5:0]   cfg_data;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  slot;
        logic [31:0] knot;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] u;
    } item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        oor;
    } point_result_t;

    typedef struct {
        item_t         it;
        bit            fixed;
        point_result_t res;
    } row_t;

    bspline_point_evaluator uut (.*);

    // predictor state
    logic [31:0]        knots [KNOT_DEPTH];
    logic signed [31:0] ptx [MAX_POINTS];
    logic signed [31:0] pty [MAX_POINTS];
    logic signed [31:0] ptz [MAX_POINTS];
    int unsigned        cur_degree;
    int unsigned        cur_count;

    point_result_t expected_points[$];
    row_t          table_rows[$];
    int  errors;
    int  mismatches;
    int  results_seen;
    int  evals_sent;
    longint cycles = 0;
    bit  out_stall_en;
    bit  in_stall_en;
    bit  long_hold;

    initial begin
        clk = 1'b0;
    end
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd4000000)
        begin
            $display("FAIL bspline_point_evaluator");
            $finish;
        end
    end

    function automatic logic signed [31:0] lerp(logic signed [31:0] p0,
                                                logic signed [31:0] p1,
                                                logic [63:0] alpha);
        logic signed [63:0] diff;
        logic signed [63:0] t;
        logic signed [63:0] q;
        logic [63:0]        mag;
        diff = 64'(p1) - 64'(p0);
        t = $signed(alpha) * diff + (64'sd1 <<< (FRAC_BITS - 1));
        if (t >= 0)
            q = t >>> FRAC_BITS;
        else
        begin
            mag = -t;
            q = -$signed((mag + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS);
        end
        return 32'(64'(p0) + q);
    endfunction

    function automatic point_result_t evaluate_curve(logic [31:0] u_in);
        point_result_t      r;
        int unsigned        d, n, i, dec, k;
        logic [31:0]        u, a, b;
        logic [63:0]        den, num, alpha;
        logic signed [31:0] wx [WORK_DEPTH];
        logic signed [31:0] wy [WORK_DEPTH];
        logic signed [31:0] wz [WORK_DEPTH];
        d = cur_degree;
        if (d < 1) d = 1;
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        n = cur_count;
        if (n < d + 1) n = d + 1;
        if (n > MAX_POINTS) n = MAX_POINTS;
        u = u_in;
        r.oor = 1'b0;
        if (u > knots[n])
        begin
            u = knots[n];
            r.oor = 1'b1;
        end
        else if (u < knots[d])
        begin
            u = knots[d];
            r.oor = 1'b1;
        end
        i = d + 1;
        while (i < n && u > knots[i])
            i++;
        dec = i - d - 1;
        for (int j = 0; j <= d; j++)
        begin
            wx[j] = ptx[dec + j];
            wy[j] = pty[dec + j];
            wz[j] = ptz[dec + j];
        end
        k = d + 1;
        for (int rr = 0; rr < d; rr++)
        begin
            for (int j = 0; j + 1 < k; j++)
            begin
                a = knots[dec + 1 + j];
                b = knots[dec + k + j];
                if (b > a)
                begin
                    den = 64'(b) - 64'(a);
                    num = (u > a) ? 64'(u) - 64'(a) : 64'd0;
                    if (num > den) num = den;
                    alpha = (num << FRAC_BITS) / den;
                    wx[j] = lerp(wx[j], wx[j + 1], alpha);
                    wy[j] = lerp(wy[j], wy[j + 1], alpha);
                    wz[j] = lerp(wz[j], wz[j + 1], alpha);
                end
            end
            dec++;
            k--;
        end
        r.x = wx[0];
        r.y = wy[0];
        r.z = wz[0];
        return r;
    endfunction

    function automatic void expect_result(point_result_t r);
        expected_points.insert(expected_points.size(), r);
    endfunction

    function automatic void add_row(item_t it, bit fixed, point_result_t res);
        row_t rw;
        rw.it = it;
        rw.fixed = fixed;
        rw.res = res;
        table_rows.insert(table_rows.size(), rw);
    endfunction

    task automatic idle_gap();
        if (in_stall_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic send_item(item_t it, bit fixed, point_result_t res);
        point_result_t p;
        idle_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {2'b00, it.u, it.pz, it.py, it.px, it.knot, it.slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (it.op)
            OP_KNOT:
            begin
                if (it.slot < KNOT_DEPTH)
                    knots[it.slot] = it.knot;
            end
            OP_POINT:
            begin
                if (it.slot < MAX_POINTS)
                begin
                    ptx[it.slot] = it.px;
                    pty[it.slot] = it.py;
                    ptz[it.slot] = it.pz;
                end
            end
            OP_EVAL:
            begin
                p = evaluate_curve(it.u);
                if (fixed && p != res)
                    errors++;
                expect_result(fixed ? res : p);
                evals_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DEGREE)
            cur_degree = val[2:0];
        else
            cur_count = val;
    endtask

    function automatic item_t mk(logic [1:0] op, logic [5:0] slot, logic [31:0] knot,
                                 logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [31:0] u);
        item_t it;
        it.op = op; it.slot = slot; it.knot = knot;
        it.px = x; it.py = y; it.pz = z; it.u = u;
        return it;
    endfunction

    // loads a clamped, nondecreasing knot vector and random points
    task automatic load_curve(bit wide);
        point_result_t none;
        logic [31:0] kv;
        int unsigned d, n;
        none = '{default: 0};
        d = cur_degree;
        n = cur_count;
        kv = 0;
        for (int i = 0; i <= n + d; i++)
        begin
            if (i > d && i <= n)
            begin
                case ($urandom_range(0, 4))
                    0: kv = kv;
                    1: kv = kv + $urandom_range(1, 255);
                    default: kv = kv + (wide ? $urandom_range(1, 32'h0800_0000)
                                             : $urandom_range(1, 32'h0004_0000));
                endcase
            end
            send_item(mk(OP_KNOT, 6'(i), kv, 0, 0, 0, 0), 0, none);
        end
        for (int i = 0; i < n; i++)
            send_item(mk(OP_POINT, 6'(i), 0, $urandom(), $urandom(), $urandom(), 0), 0,
                      none);
    endtask

    task automatic random_items(int count);
        point_result_t none;
        item_t it;
        int unsigned hi;
        none = '{default: 0};
        hi = knots[cur_count];
        for (int c = 0; c < count; c++)
        begin
            it = mk(OP_EVAL, 6'($urandom()), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
            case ($urandom_range(0, 9))
                0: it.op = OP_NOP;
                1:
                begin
                    it.op = OP_KNOT;
                    it.slot = 6'($urandom_range(KNOT_DEPTH, 63));
                end
                2:
                begin
                    it.op = OP_POINT;
                    it.slot = 6'($urandom_range(MAX_POINTS, 63));
                end
                3: it.op = OP_EVAL;
                default:
                begin
                    it.op = OP_EVAL;
                    it.u = knots[cur_degree] + $urandom_range(0, hi - knots[cur_degree]);
                end
            endcase
            send_item(it, 0, none);
        end
    endtask

    initial begin : receiver
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                long_hold = 0;
            end
            else if (out_stall_en && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        point_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_points.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %h", m_axis_tdata);
            end
            else
            begin
                e = expected_points.pop_front();
                if (m_axis_tdata != {e.z, e.y, e.x} || m_axis_tuser != e.oor)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h oor=%b got %h oor=%b",
                                 e.x, e.y, e.z, e.oor, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        point_result_t none;
        int degs[6];
        int cnts[6];
        none = '{default: 0};
        errors = 0;
        mismatches = 0;
        results_seen = 0;
        evals_sent = 0;
        out_stall_en = 0;
        in_stall_en = 0;
        long_hold = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_degree = 3;
        cur_count = 4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, uniform knots 0..7 (units), constant points
        for (int i = 0; i <= 7; i++)
            add_row(mk(OP_KNOT, 6'(i), i << 16, 0, 0, 0, 0), 0, none);
        for (int i = 0; i < 4; i++)
            add_row(mk(OP_POINT, 6'(i), 0, 32'h7fff_ffff, 32'h8000_0000,
                       32'h0001_0000, 0), 0, none);
        // constant control polygon reproduces itself, in and out of range
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'h0003_8000), 1,
                '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b0});
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'h0000_0000), 1,
                '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b1});
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'hffff_ffff), 1,
                '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b1});
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'h0004_0000), 1,
                '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b0});
        // alternating extremes, ignored writes and op 3
        add_row(mk(OP_POINT, 1, 0, 32'h8000_0000, 32'h7fff_ffff,
                   32'hffff_ffff, 0), 0, none);
        add_row(mk(OP_POINT, 63, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(OP_KNOT, 63, 32'hffff_ffff, 0, 0, 0, 0), 0, none);
        add_row(mk(OP_NOP, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'h0003_0000), 0, none);
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'h0003_c000), 0, none);
        // repeated knot: zero difference keeps the left point
        add_row(mk(OP_KNOT, 4, 32'h0003_0000, 0, 0, 0, 0), 0, none);
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'h0003_0000), 0, none);
        add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 32'h0003_4000), 0, none);
        foreach (table_rows[r])
            send_item(table_rows[r].it, table_rows[r].fixed, table_rows[r].res);
        drain();

        // configuration sweep including extremes and saturation
        degs = '{1, 7, 0, 2, 5, 3};
        cnts = '{2, 32, 1, 40, 9, 6};
        in_stall_en = 1;
        out_stall_en = 1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_DEGREE, 6'(degs[ph]));
            write_reg(CFG_POINT_COUNT, 6'(cnts[ph]));
            begin
                int unsigned d, n;
                d = (cur_degree < 1) ? 1 : cur_degree;
                n = (cur_count < d + 1) ? d + 1 : (cur_count > MAX_POINTS ? MAX_POINTS
                                                                          : cur_count);
                // load tables for the effective sizes
                cur_degree = d;
                cur_count = n;
                load_curve((ph % 2) == 1);
                if (ph == 1)
                    long_hold = 1;
                if (ph == 5)
                begin
                    in_stall_en = 0;
                    out_stall_en = 0;
                end
                random_items((ph == 1) ? 40 : 200);
                cur_degree = degs[ph];
                cur_count = cnts[ph];
            end
            drain();
        end

        $display("covered %0d evaluations across degrees 1..7 and point counts 2..32,",
                 evals_sent);
        $display("with clamped parameters, repeated knots and stalls on both sides");
        if (errors == 0 && expected_points.size() == 0)
            $display("PASS bspline_point_evaluator");
        else
            $display("FAIL bspline_point_evaluator");
        $finish;
    end
endmodule
